FILE: rtl/ncas_pkg.sv
// ----------------------------------------------------------------------------
// ncas_pkg
// Shared constants and types for the nearest-centroid anomaly scorer.
// ----------------------------------------------------------------------------
package ncas_pkg;

    localparam int CLUSTERS = 8;
    localparam int FEATURES = 16;
    localparam int CL_W     = 3;
    localparam int FT_W     = 4;
    localparam int DIST_W   = 37;
    localparam int SCORE_W  = 18;
    localparam int CNT_W    = 20;
    localparam int SUM_W    = 38;
    localparam int SQS_W    = 56;
    localparam int THR_W    = 24;

    localparam logic [1:0] OP_LOAD     = 2'd0;
    localparam logic [1:0] OP_VALIDATE = 2'd1;
    localparam logic [1:0] OP_PREDICT  = 2'd2;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [THR_W-1:0]  THR_MAX  = {THR_W{1'b1}};

    localparam logic CFG_MEAN_WEIGHT   = 1'b0;
    localparam logic CFG_SPREAD_WEIGHT = 1'b1;

    // Request to the shared square-root / divide unit.
    typedef struct packed {
        logic        start;
        logic        is_div;     // 1: quotient, 0: square root
        logic [63:0] num;
        logic [37:0] den;
    } t_arith_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] res;
    } t_arith_rsp;

endpackage

FILE: rtl/nearest_centroid_anomaly_scorer.sv
// ----------------------------------------------------------------------------
// nearest_centroid_anomaly_scorer
// Top level: configuration registers, input handshake and output register.
// ----------------------------------------------------------------------------
// Point element: one centroid read ahead, then eight clusters one per cycle
// through the centroid memory port. Last element: nearest search, square root
// in the shared unit and statistics update follow before the result word.
// Entering predict adds a freeze sweep through the shared divide unit; leaving
// it adds a statistics clear, as does the clearing pass after reset.
// Reset is synchronous, active low; the centroid table reads zero until loaded.
module nearest_centroid_anomaly_scorer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [15:0]                  i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_operation,
    input  logic [2:0]                   i_cluster_index,
    input  logic [3:0]                   i_feature_index,
    input  logic signed [15:0]           i_feature_value,
    input  logic                         i_last_element,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [2:0]                   o_nearest_cluster,
    output logic [17:0]                  o_score,
    output logic [23:0]                  o_threshold,
    output logic [19:0]                  o_cluster_count,
    output logic                         o_frozen
);
    import ncas_pkg::*;

    logic [15:0] r_mean_weight, r_spread_weight;
    logic        w_busy, w_rv, r_valid;
    logic [2:0]  w_nc;
    logic [17:0] w_sc;
    logic [23:0] w_th;
    logic [19:0] w_cc;
    logic        w_fr;
    t_arith_req  w_req;
    t_arith_rsp  w_rsp;

    // hold input while the sequencer works or a word waits at the output
    assign o_stall = w_busy || (r_valid && i_stall);
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean_weight   <= 16'd256;
            r_spread_weight <= 16'd768;
            r_valid         <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_MEAN_WEIGHT) r_mean_weight <= i_cfg_data;
            if (i_cfg_we && i_cfg_index == CFG_SPREAD_WEIGHT) r_spread_weight <= i_cfg_data;
            if (w_rv) r_valid <= 1'b1;
            else if (!i_stall) r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rv) begin
            o_nearest_cluster <= w_nc;
            o_score           <= w_sc;
            o_threshold       <= w_th;
            o_cluster_count   <= w_cc;
            o_frozen          <= w_fr;
        end
    end

    ncas_core u_core (
        .i_clk, .i_rst_n,
        .i_mean_weight(r_mean_weight), .i_spread_weight(r_spread_weight),
        .i_valid(i_valid && !o_stall), .o_busy(w_busy),
        .i_operation, .i_cluster_index, .i_feature_index, .i_feature_value,
        .i_last_element,
        .o_res_valid(w_rv), .o_nearest_cluster(w_nc), .o_score(w_sc),
        .o_threshold(w_th), .o_cluster_count(w_cc), .o_frozen(w_fr),
        .o_req(w_req), .i_rsp(w_rsp)
    );

    ncas_arith u_arith (.i_clk, .i_rst_n, .i_req(w_req), .o_rsp(w_rsp));

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> o_stall) else $error("accept while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |=> r_valid) else $error("result dropped");
    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rv |-> !(r_valid && i_stall)) else $error("result overwritten");
`endif
endmodule

FILE: rtl/ncas_arith.sv
// ----------------------------------------------------------------------------
// ncas_arith
// Shared iterative unit: integer square root or unsigned divide, 2 bits or
// 1 bit per cycle.
// ----------------------------------------------------------------------------
module ncas_arith (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ncas_pkg::t_arith_req i_req,
    output ncas_pkg::t_arith_rsp o_rsp
);
    import ncas_pkg::*;

    logic        r_busy, r_done, r_div;
    logic [6:0]  r_cnt;
    logic [63:0] r_num, r_res;
    logic [64:0] r_rem;
    logic [37:0] r_den;
    logic [64:0] w_trial, w_rsh;
    logic [64:0] w_sub;

    always_comb begin
        if (r_div) begin
            w_rsh   = {r_rem[63:0], r_num[63]};
            w_trial = {27'd0, r_den};
        end else begin
            w_rsh   = {r_rem[62:0], r_num[63:62]};
            w_trial = {r_res[62:0], 2'b01};
        end
        w_sub = w_rsh - w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_div  <= i_req.is_div;
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_res  <= '0;
                r_cnt  <= i_req.is_div ? 7'd64 : 7'd32;
            end else if (r_busy) begin
                if (!w_sub[64]) begin
                    r_rem <= w_sub;
                    r_res <= {r_res[62:0], 1'b1};
                end else begin
                    r_rem <= w_rsh;
                    r_res <= {r_res[62:0], 1'b0};
                end
                r_num <= r_div ? {r_num[62:0], 1'b0} : {r_num[61:0], 2'b00};
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;
endmodule

FILE: rtl/ncas_core.sv
// ----------------------------------------------------------------------------
// ncas_core
// Sequencer: centroid and statistics memories, distance accumulation,
// nearest search, statistics update, and the clear and freeze sweeps.
// ----------------------------------------------------------------------------
module ncas_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [15:0]                   i_mean_weight,
    input  logic [15:0]                   i_spread_weight,
    input  logic                          i_valid,
    output logic                          o_busy,
    input  logic [1:0]                    i_operation,
    input  logic [2:0]                    i_cluster_index,
    input  logic [3:0]                    i_feature_index,
    input  logic signed [15:0]            i_feature_value,
    input  logic                          i_last_element,
    output logic                          o_res_valid,
    output logic [ncas_pkg::CL_W-1:0]     o_nearest_cluster,
    output logic [ncas_pkg::SCORE_W-1:0]  o_score,
    output logic [ncas_pkg::THR_W-1:0]    o_threshold,
    output logic [ncas_pkg::CNT_W-1:0]    o_cluster_count,
    output logic                          o_frozen,
    output ncas_pkg::t_arith_req          o_req,
    input  ncas_pkg::t_arith_rsp          i_rsp
);
    import ncas_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_FRZ_RD, S_FRZ_MEAN, S_FRZ_MSQ, S_FRZ_VAR, S_FRZ_SQRT,
        S_FRZ_WR, S_DIST, S_SEL, S_SQRT, S_STAT_RD, S_STAT_WR
    } t_state;

    // centroid memory, one read port; a written flag per entry reads zero until loaded
    logic [15:0] m_cent [CLUSTERS*FEATURES];
    logic [15:0] r_cent_q;
    logic [CLUSTERS*FEATURES-1:0] r_cent_ok;
    logic        r_cent_ok_q;
    // statistics memory: count, sum, square sum, threshold per cluster
    logic [CNT_W+SUM_W+SQS_W+THR_W-1:0] m_stat [CLUSTERS];
    logic [CNT_W+SUM_W+SQS_W+THR_W-1:0] r_stat_q;

    logic [DIST_W-1:0] r_dist [CLUSTERS];

    t_state            r_state;
    logic [CL_W:0]     r_j;
    logic [3:0]        r_fi;
    logic signed [15:0] r_x;
    logic              r_last, r_fi_ok, r_frozen, r_rdv, r_resume;
    logic [CL_W-1:0]   r_best;
    logic [DIST_W-1:0] r_dmin;
    logic [SCORE_W-1:0] r_score;
    logic [63:0]       r_mean, r_msq;
    t_arith_req        r_req;
    logic              r_res_valid;

    logic [CL_W-1:0]   w_j;
    logic [CL_W-1:0]   w_rd_j;
    logic              w_load;
    logic [15:0]       w_cent;
    logic signed [16:0] w_d;
    logic [16:0]       w_a;
    logic [33:0]       w_sq;
    logic [DIST_W:0]   w_sum;
    logic [CNT_W-1:0]  s_cnt;
    logic [SUM_W-1:0]  s_sum;
    logic [SQS_W-1:0]  s_sqs;
    logic [THR_W-1:0]  s_thr;
    logic [63:0]       w_m2, w_var;
    logic [41:0]       w_t;

    assign w_j = r_j[CL_W-1:0];
    // read one cluster ahead once data is flowing
    assign w_rd_j = r_rdv ? w_j + CL_W'(1) : w_j;
    assign w_load = i_valid && !o_busy && i_operation == OP_LOAD
                    && 32'(i_cluster_index) < CLUSTERS && 32'(i_feature_index) < FEATURES;
    assign {s_cnt, s_sum, s_sqs, s_thr} = r_stat_q;
    assign w_cent = r_cent_ok_q ? r_cent_q : 16'd0;
    assign w_d  = {r_x[15], r_x} - {w_cent[15], w_cent};
    assign w_a  = w_d[16] ? 17'(-w_d) : 17'(w_d);
    assign w_sq = 34'(w_a) * 34'(w_a);
    assign w_sum = {1'b0, r_dist[w_j]} + (DIST_W+1)'(w_sq);
    assign w_m2  = 64'(36'(r_mean[SCORE_W-1:0]) * 36'(r_mean[SCORE_W-1:0]));
    assign w_var = (r_msq > w_m2) ? r_msq - w_m2 : 64'd0;
    assign w_t = (42'(i_mean_weight) * 42'(r_mean[25:0])
                 + 42'(i_spread_weight) * 42'(i_rsp.res[25:0])) >> 8;

    assign o_busy = (r_state != S_IDLE) || r_res_valid;
    assign o_req  = r_req;
    assign o_res_valid = r_res_valid;
    assign o_frozen = r_frozen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_cent_ok <= '0;
        else if (w_load)
            r_cent_ok[{i_cluster_index, i_feature_index}] <= 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (w_load)
            m_cent[{i_cluster_index, i_feature_index}] <= i_feature_value;
        r_cent_q    <= m_cent[{w_rd_j, r_fi}];
        r_cent_ok_q <= r_cent_ok[{w_rd_j, r_fi}];
        r_stat_q <= m_stat[(r_state == S_STAT_RD) ? r_best : w_j];
        if (r_state == S_CLR)
            m_stat[w_j] <= '0;
        else if (r_state == S_FRZ_WR)
            m_stat[w_j] <= {s_cnt, s_sum, s_sqs,
                (s_cnt == '0) ? THR_W'(0)
                : (w_t > 42'(THR_MAX)) ? THR_MAX : w_t[THR_W-1:0]};
        else if (r_state == S_STAT_WR && !r_frozen && s_cnt != CNT_MAX)
            m_stat[r_best] <= {s_cnt + CNT_W'(1), s_sum + SUM_W'(r_score),
                s_sqs + SQS_W'(36'(r_score) * 36'(r_score)), s_thr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_j         <= '0;
            r_frozen    <= 1'b0;
            r_rdv       <= 1'b0;
            r_resume    <= 1'b0;
            r_res_valid <= 1'b0;
            r_req.start <= 1'b0;
            for (int k = 0; k < CLUSTERS; k++) r_dist[k] <= '0;
        end else begin
            r_req.start <= 1'b0;
            r_res_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && (i_operation == OP_VALIDATE
                                    || i_operation == OP_PREDICT)) begin
                        r_x     <= i_feature_value;
                        r_fi    <= i_feature_index;
                        r_fi_ok <= 32'(i_feature_index) < FEATURES;
                        r_last  <= i_last_element;
                        r_j     <= '0;
                        r_rdv   <= 1'b0;
                        if (i_operation == OP_VALIDATE && r_frozen) begin
                            r_frozen <= 1'b0;
                            r_resume <= 1'b1;
                            r_state  <= S_CLR;
                        end else if (i_operation == OP_PREDICT && !r_frozen) begin
                            r_frozen <= 1'b1;
                            r_state  <= S_FRZ_RD;
                        end else begin
                            r_state <= S_DIST;
                        end
                    end
                end
                S_CLR: begin
                    // sweep statistics clear (also the reset pass)
                    r_j <= r_j + 1'b1;
                    if (32'(r_j) == CLUSTERS - 1) begin
                        r_j      <= '0;
                        r_resume <= 1'b0;
                        r_state  <= r_resume ? S_DIST : S_IDLE;
                    end
                end
                S_FRZ_RD: r_state <= S_FRZ_MEAN;
                S_FRZ_MEAN: begin
                    if (s_cnt == '0) begin
                        r_state <= S_FRZ_WR;
                    end else begin
                        r_req   <= '{1'b1, 1'b1, 64'(s_sum), 38'(s_cnt)};
                        r_state <= S_FRZ_MSQ;
                    end
                end
                S_FRZ_MSQ: begin
                    if (i_rsp.done) begin
                        r_mean  <= i_rsp.res;
                        r_req   <= '{1'b1, 1'b1, 64'(s_sqs), 38'(s_cnt)};
                        r_state <= S_FRZ_VAR;
                    end
                end
                S_FRZ_VAR: begin
                    if (i_rsp.done) begin
                        r_msq   <= i_rsp.res;
                        r_state <= S_FRZ_SQRT;
                    end
                end
                S_FRZ_SQRT: begin
                    r_req <= '{1'b1, 1'b0, w_var, 38'd0};
                    r_state <= S_FRZ_WR;
                end
                S_FRZ_WR: begin
                    if (s_cnt == '0 || i_rsp.done) begin
                        r_j <= r_j + 1'b1;
                        if (32'(r_j) == CLUSTERS - 1) begin
                            r_j <= '0;
                            r_state <= S_DIST;
                        end else begin
                            r_state <= S_FRZ_RD;
                        end
                    end
                end
                S_DIST: begin
                    // one cluster a cycle; r_rdv marks centroid read data valid
                    r_rdv <= 1'b1;
                    if (r_rdv) begin
                        if (r_fi_ok)
                            r_dist[w_j] <= w_sum[DIST_W] ? DIST_MAX : w_sum[DIST_W-1:0];
                        r_j <= r_j + 1'b1;
                        if (32'(r_j) == CLUSTERS - 1) begin
                            r_j <= '0;
                            r_rdv <= 1'b0;
                            r_state <= r_last ? S_SEL : S_IDLE;
                        end
                    end
                end
                S_SEL: begin
                    if (r_j == '0 || r_dist[w_j] < r_dmin) begin
                        r_dmin <= r_dist[w_j];
                        r_best <= w_j;
                    end
                    r_j <= r_j + 1'b1;
                    if (32'(r_j) == CLUSTERS - 1) begin
                        r_j <= '0;
                        r_state <= S_SQRT;
                        r_req <= '{1'b1, 1'b0, 64'(r_dmin), 38'd0};
                        if (r_dist[w_j] < r_dmin)
                            r_req.num <= 64'(r_dist[w_j]);
                        for (int k = 0; k < CLUSTERS; k++) r_dist[k] <= '0;
                    end
                end
                S_SQRT: begin
                    if (i_rsp.done) begin
                        // saturate the root of a very large distance
                        r_score <= (|i_rsp.res[63:SCORE_W]) ? {SCORE_W{1'b1}}
                                   : i_rsp.res[SCORE_W-1:0];
                        r_state <= S_STAT_RD;
                    end
                end
                S_STAT_RD: r_state <= S_STAT_WR;
                S_STAT_WR: begin
                    o_nearest_cluster <= r_best;
                    o_score     <= r_score;
                    o_threshold <= s_thr;
                    o_cluster_count <= (!r_frozen && s_cnt != CNT_MAX)
                                       ? s_cnt + CNT_W'(1) : s_cnt;
                    r_res_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
